@@ rtl/swm_pkg.sv @@
// Package for the sliding window maximum filter.
// Holds word types and fixed widths; no dependencies.
package swm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int CFG_W    = 7;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CFG_W-1:0]           cfg_t;

	// Most negative sample, used to seed the maximum wavefront.
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef struct packed {
		sample_t sample;
		logic    end_of_sequence;
	} in_word_t;

	typedef struct packed {
		sample_t window_max;
		logic    final_result;
	} out_word_t;

endpackage

@@ rtl/swm_if.sv @@
// Valid/ready channel interfaces for the sliding window maximum filter.
// Depends on swm_pkg for the word types.
interface swm_in_if;
	import swm_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface swm_out_if;
	import swm_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/sliding_window_max.sv @@
// Top level of the sliding window maximum filter: controller and cell chain.
// Depends on swm_pkg, swm_if, swm_cell and swm_ctrl.
//
//   channel   dir  payload                       handshake
//   samples   in   sample, end_of_sequence       valid/ready
//   results   out  window_max, final_result      valid/ready
//   cfg       in   window_size (7 bits)          cfg_we, no wait
//
// A word that yields a result starts a scan in which the maximum crosses the
// chain one cell per cycle; no new word is accepted until the scan ends.
// A word that yields no result leaves the filter ready for the next word.
// Reset clears the fill count and sets the window size to one; the history
// cells are not cleared. A stalled result holds in the output register, and a
// new word is accepted while it waits.
module sliding_window_max #(
	parameter int MAX_WINDOW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	swm_in_if.sink        samples,
	swm_out_if.source     results,
	input  logic          cfg_we,
	input  swm_pkg::cfg_t cfg_wdata
);
	import swm_pkg::*;

	localparam int KW = $clog2(MAX_WINDOW+1);

	logic          shift;
	logic [KW-1:0] k;
	sample_t       sample_w [0:MAX_WINDOW];
	sample_t       max_w    [0:MAX_WINDOW];

	assign sample_w[0] = samples.data.sample;
	assign max_w[0]    = SAMPLE_MIN;

	swm_ctrl #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.results   (results),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.chain_max (max_w[MAX_WINDOW]),
		.shift     (shift),
		.k         (k)
	);

	// Chain of history cells; cell i holds the sample i words back.
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		swm_cell #(
			.MAX_WINDOW(MAX_WINDOW),
			.INDEX     (i)
		) u_cell (
			.clk        (clk),
			.shift      (shift),
			.k          (k),
			.sample_in  (sample_w[i]),
			.max_in     (max_w[i]),
			.sample_out (sample_w[i+1]),
			.max_out    (max_w[i+1])
		);
	end

endmodule

@@ rtl/swm_cell.sv @@
// One cell of the history chain: a stored sample and a registered max stage.
// Depends on swm_pkg.
module swm_cell #(
	parameter int MAX_WINDOW = 64,
	parameter int INDEX      = 0
) (
	input  logic                           clk,
	input  logic                           shift,
	input  logic [$clog2(MAX_WINDOW+1)-1:0] k,
	input  swm_pkg::sample_t               sample_in,
	input  swm_pkg::sample_t               max_in,
	output swm_pkg::sample_t               sample_out,
	output swm_pkg::sample_t               max_out
);
	import swm_pkg::*;

	localparam int KW = $clog2(MAX_WINDOW+1);

	sample_t sample_q;
	sample_t max_q;
	logic    in_window;

	// The cell takes part only when it lies inside the current window.
	assign in_window = KW'(INDEX) < k;

	// Samples move one cell down the chain on each accepted word.
	always_ff @(posedge clk) begin
		if (shift) begin
			sample_q <= sample_in;
		end
	end

	// The running maximum moves one cell per cycle.
	always_ff @(posedge clk) begin
		if (in_window && (sample_q > max_in)) begin
			max_q <= sample_q;
		end else begin
			max_q <= max_in;
		end
	end

	assign sample_out = sample_q;
	assign max_out    = max_q;

endmodule

@@ rtl/swm_ctrl.sv @@
// Controller: handshakes, window register, fill count, scan timing, output register.
// Depends on swm_pkg and the channel interfaces in swm_if.
module swm_ctrl #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	swm_in_if.sink                          samples,
	swm_out_if.source                       results,
	input  logic                            cfg_we,
	input  swm_pkg::cfg_t                   cfg_wdata,
	input  swm_pkg::sample_t                chain_max,
	output logic                            shift,
	output logic [$clog2(MAX_WINDOW+1)-1:0] k
);
	import swm_pkg::*;

	localparam int KW = $clog2(MAX_WINDOW+1);
	localparam int CW = (KW > CFG_W) ? KW : CFG_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;

	logic [1:0]    state_q;
	cfg_t          window_q;
	logic [KW-1:0] fill_q;
	logic [KW-1:0] fill_next;
	logic [KW-1:0] cnt_q;
	logic          eos_q;
	logic          out_valid_q;
	out_word_t     out_q;
	logic          produce;
	logic          scan_done;
	logic          out_free;

	// Window length clamped to the chain depth.
	always_comb begin
		if (CW'(window_q) > CW'(MAX_WINDOW)) begin
			k = KW'(MAX_WINDOW);
		end else begin
			k = KW'(window_q);
		end
	end

	assign samples.ready = (state_q == ST_IDLE);
	assign shift         = samples.valid && samples.ready;

	// Saturating fill count including the word being accepted.
	assign fill_next = (fill_q == KW'(MAX_WINDOW)) ? fill_q : fill_q + KW'(1);
	assign produce   = (k != '0) && (fill_next >= k);

	assign out_free  = !out_valid_q || results.ready;
	assign scan_done = (state_q == ST_SCAN) && (cnt_q == KW'(MAX_WINDOW)) && out_free;

	// Window size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= cfg_t'(1);
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// Sequencer: wait for a word; if it yields a result, let the maximum run the whole chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (shift) begin
						fill_q <= samples.data.end_of_sequence ? '0 : fill_next;
						cnt_q  <= '0;
						if (produce) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (cnt_q != KW'(MAX_WINDOW)) begin
						cnt_q <= cnt_q + KW'(1);
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// End flag of the word under scan.
	always_ff @(posedge clk) begin
		if (shift) begin
			eos_q <= samples.data.end_of_sequence;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (scan_done) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (scan_done) begin
			out_q.window_max   <= chain_max;
			out_q.final_result <= eos_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

endmodule
